>>> rtl/core/dbq_pkg.sv
// ----------------------------------------------------------------------------
// dbq_pkg
// Shared constants, codes and control structs for the bounded deque.
// ----------------------------------------------------------------------------
`default_nettype none

package dbq_pkg;

    // Storage geometry.
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = $clog2(2 * DEPTH);

    // Port widths fixed by the interface.
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 7;
    localparam int CMP_W  = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_L = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_R = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_L  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_R  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_PUSHED_L = 3'd0;
    localparam logic [ST_W-1:0] ST_PUSHED_R = 3'd1;
    localparam logic [ST_W-1:0] ST_POPPED_L = 3'd2;
    localparam logic [ST_W-1:0] ST_POPPED_R = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;
    localparam logic [ST_W-1:0] ST_CLEARED  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } dbq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_op_known;
        logic out_free;
    } dbq_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue over a circular entry RAM with a programmable capacity.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel (in_valid / in_stall) carries one beat per request: an
// operation code and a signed word that only pushes use. The output channel
// (out_valid / out_stall) returns one beat per request with a status code and
// the value pushed or popped; refused pushes, pops from an empty queue and
// clears return a zero value. Undefined operation codes are taken and dropped
// without a reply and without touching the queue.
// A request is captured, executed against the queue and then loaded into
// the output register as its reply; no new request is taken until that
// reply is loaded. The registered read port of the entry RAM sets the
// execute step, since a popped word leaves the RAM through its read register.
// A finished reply sits in an output register, so the block is ready for the
// next request while that reply waits; if the receiver is still stalling
// when the next reply is ready, the sequencer holds in its reply step and
// keeps in_stall high until the output register frees up.
// Reset empties the queue, rewinds the left-end pointer and sets the capacity
// register to 64. The capacity may be written through cfg_wr_en/cfg_wr_data
// only while no request is in flight; it never alters the held entries.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue
    import dbq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CAP_W-1:0]        cfg_wr_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [OP_W-1:0]         operation,
    input  wire logic signed [VAL_W-1:0] push_value,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [ST_W-1:0]              status,
    output logic signed [VAL_W-1:0]      result_value
);

    dbq_cmd_t cmd;
    dbq_sts_t sts;

    // The sequencer owns the input handshake and decides when each step runs.
    dbq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the pointers, the entry RAM and the output register.
    dbq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .operation    (operation),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_value (result_value)
    );

endmodule

`default_nettype wire

>>> rtl/core/dbq_ram.sv
// ----------------------------------------------------------------------------
// dbq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                   wdata,
    input  wire logic                               re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dbq_ctrl.sv
// ----------------------------------------------------------------------------
// dbq_ctrl
// Sequencer that takes one beat at a time through capture, execute and reply.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_ctrl
    import dbq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire dbq_sts_t sts,
    output dbq_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.load_out = 1'b0;
        in_stall     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                // Beats with an undefined operation are absorbed here.
                if (in_valid && sts.in_op_known)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                cmd.load_out = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dbq_dp.sv
// ----------------------------------------------------------------------------
// dbq_dp
// Pointer and occupancy tracking, entry RAM, capacity register and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_dp
    import dbq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dbq_cmd_t                cmd,
    output dbq_sts_t                     sts,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CAP_W-1:0]        cfg_wr_data,
    input  wire logic [OP_W-1:0]         operation,
    input  wire logic signed [VAL_W-1:0] push_value,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [ST_W-1:0]              status,
    output logic signed [VAL_W-1:0]      result_value
);

    logic [OP_W-1:0]       op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [ST_W-1:0]       pend_status_reg, pend_status_next;
    logic [DATA_WIDTH-1:0] pend_value_reg, pend_value_next;
    logic                  from_ram_reg, from_ram_next;
    logic                  out_valid_reg;
    logic [ST_W-1:0]       out_status_reg;
    logic [VAL_W-1:0]      out_value_reg;

    logic                  ram_we;
    logic                  ram_re;
    logic [PTR_W-1:0]      ram_waddr;
    logic [PTR_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      eff_cap;
    logic                  is_full;
    logic                  is_empty;
    logic [PTR_W-1:0]      front_dec;
    logic [PTR_W-1:0]      front_inc;
    logic [SUM_W-1:0]      tail_sum;
    logic [SUM_W-1:0]      last_sum;
    logic [PTR_W-1:0]      tail_slot;
    logic [PTR_W-1:0]      last_slot;

    assign sts.in_op_known = (operation <= OP_CLEAR);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    // Effective capacity is the register saturated at the store depth.
    assign cap_ext  = CMP_W'(cap_reg);
    assign eff_cap  = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign is_full  = CMP_W'(occ_reg) >= eff_cap;
    assign is_empty = (occ_reg == '0);

    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    // Slot one past the right end, and the right end itself; both stay below 2*DEPTH.
    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(occ_reg);
    assign last_sum  = tail_sum - 1'b1;
    assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                   : PTR_W'(tail_sum);
    assign last_slot = (last_sum >= SUM_W'(DEPTH)) ? PTR_W'(last_sum - SUM_W'(DEPTH))
                                                   : PTR_W'(last_sum);

    always_comb
    begin
        front_next       = front_reg;
        occ_next         = occ_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        from_ram_next    = from_ram_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_waddr        = tail_slot;
        ram_raddr        = front_reg;
        if (cmd.execute)
        begin
            pend_value_next = '0;
            from_ram_next   = 1'b0;
            case (op_reg)
                OP_PUSH_L, OP_PUSH_R:
                begin
                    if (is_full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        occ_next        = occ_reg + 1'b1;
                        pend_value_next = val_reg;
                        if (op_reg == OP_PUSH_L)
                        begin
                            ram_waddr        = front_dec;
                            front_next       = front_dec;
                            pend_status_next = ST_PUSHED_L;
                        end
                        else
                        begin
                            pend_status_next = ST_PUSHED_R;
                        end
                    end
                end
                OP_POP_L, OP_POP_R:
                begin
                    if (is_empty)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ram_re        = 1'b1;
                        from_ram_next = 1'b1;
                        occ_next      = occ_reg - 1'b1;
                        if (op_reg == OP_POP_L)
                        begin
                            front_next       = front_inc;
                            pend_status_next = ST_POPPED_L;
                        end
                        else
                        begin
                            ram_raddr        = last_slot;
                            pend_status_next = ST_POPPED_R;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    front_next       = '0;
                    occ_next         = '0;
                    pend_status_next = ST_CLEARED;
                end
                default:
                begin
                    pend_status_next = pend_status_reg;
                end
            endcase
        end
    end

    dbq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            occ_reg       <= '0;
            cap_reg       <= CAP_RESET;
            from_ram_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            occ_reg      <= occ_next;
            from_ram_reg <= from_ram_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            val_reg <= push_value[DATA_WIDTH-1:0];
        end
        pend_status_reg <= pend_status_next;
        pend_value_reg  <= pend_value_next;
        if (cmd.load_out)
        begin
            out_status_reg <= pend_status_reg;
            out_value_reg  <= from_ram_reg ? VAL_W'(ram_rdata) : VAL_W'(pend_value_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = signed'(out_value_reg);

endmodule

`default_nettype wire

>>> rtl/core/dbq_checker.sv
// ----------------------------------------------------------------------------
// dbq_checker
// Port-level checks for the bounded deque, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_checker
    import dbq_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire logic [OP_W-1:0]         operation,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic [ST_W-1:0]         status,
    input wire logic signed [VAL_W-1:0] result_value
);

    // A stalled reply beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_value))
        else $error("reply beat changed while stalled");

    // Refusals and clears carry a zero value.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL || status == ST_EMPTY || status == ST_CLEARED)
        |-> result_value == '0)
        else $error("refused or cleared reply carries a value");

    // Status code seven is never produced.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_CLEARED)
        else $error("undefined status code");

    // Once a defined request is taken, the next cycle does not take another.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation <= OP_CLEAR |=> in_stall)
        else $error("second request taken while one is in flight");

    // A reply never appears in the cycle right after a request is taken.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation <= OP_CLEAR && !out_valid |=> !out_valid)
        else $error("reply appeared too early");

endmodule

bind bounded_double_ended_queue dbq_checker u_dbq_checker (.*);

`default_nettype wire
